### rtl/core/pdd_pkg.sv
// Package for the port device detection debouncer.
// Holds the device codes, the per-port state entry type and the sample classifier.
// No dependencies.
package pdd_pkg;

   localparam int unsigned PORT_W = 3;
   localparam int unsigned CODE_W = 4;
   localparam int unsigned CNT_W  = 4;
   localparam int unsigned ID_W   = 32;

   localparam logic [CODE_W-1:0] CODE_NOTHING  = 4'd0;
   localparam logic [CODE_W-1:0] CODE_LIGHT    = 4'd1;
   localparam logic [CODE_W-1:0] CODE_DIAL     = 4'd2;
   localparam logic [CODE_W-1:0] CODE_DISTANCE = 4'd3;
   localparam logic [CODE_W-1:0] CODE_SOUND    = 4'd4;
   localparam logic [CODE_W-1:0] CODE_SERVO    = 4'd5;
   localparam logic [CODE_W-1:0] CODE_MATRIX   = 4'd6;
   localparam logic [CODE_W-1:0] CODE_PLACE    = 4'd7;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 4'd8;

   localparam logic [CNT_W-1:0] COUNT_MAX   = 4'd15;
   localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd5;

   typedef struct packed {
      logic [CODE_W-1:0] pending;
      logic              connecting;
      logic [CNT_W-1:0]  conn_cnt;
      logic [CNT_W-1:0]  disc_cnt;
   } entry_type;

   function automatic logic [CODE_W-1:0] classify(input logic [7:0] v);
      logic [CODE_W-1:0] code;
      if (v > 8'd100 && v <= 8'd110)      code = CODE_LIGHT;
      else if (v > 8'd130 && v <= 8'd140) code = CODE_DIAL;
      else if (v > 8'd100 && v <= 8'd120) code = CODE_DISTANCE;
      else if (v > 8'd110 && v <= 8'd120) code = CODE_SOUND;
      else if (v > 8'd70 && v <= 8'd90)   code = CODE_SERVO;
      else if (v > 8'd20 && v <= 8'd50)   code = CODE_MATRIX;
      else if (v > 8'd180 && v <= 8'd240) code = CODE_PLACE;
      else if (v > 8'd240)                code = CODE_NOTHING;
      else                                code = CODE_UNKNOWN;
      return code;
   endfunction

endpackage

### rtl/core/port_device_detect_debounce_core.sv
// Port device detection debouncer, top level.
// Per-port debounce state in a synchronous memory, committed codes in flops.
// Depends on pdd_pkg.

// One item (port index and detection sample) is taken per cycle unless stalled
// and gives one registered result: the port's committed device code and a 32-bit
// identifier packed from the committed codes of all ports. The pending code and
// both debounce counters of each port live in a small synchronous memory
// read when the item is taken and written back as it leaves stage 1; an item for
// the port just updated picks the new entry up from a forwarding register, so
// items may follow each other every cycle in any port order. A full output
// register with rsp_ready low stalls the one pipeline stage and then req_ready.
// A port index beyond the configured ports changes nothing and reports code 0.
// csr_wr_en loads the debounce limit (reset 5); a limit of 15 never commits.
module port_device_detect_debounce_core #(
   parameter int unsigned OUT_PORTS = 4,
   parameter int unsigned IN_PORTS  = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pdd_pkg::CNT_W-1:0]          csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pdd_pkg::PORT_W-1:0]         req_port,
   input  logic [7:0]                         req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pdd_pkg::PORT_W-1:0]         rsp_port_out,
   output logic [pdd_pkg::CODE_W-1:0]         rsp_stable_code,
   output logic [pdd_pkg::ID_W-1:0]           rsp_identifier
);

   localparam int unsigned NUM_PORTS = OUT_PORTS + IN_PORTS;
   localparam int unsigned AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam logic [pdd_pkg::PORT_W-1:0] PORT_LIMIT = pdd_pkg::PORT_W'(NUM_PORTS);

   logic [pdd_pkg::CNT_W-1:0]  limit_ff;

   pdd_pkg::entry_type         mem [NUM_PORTS];
   logic [NUM_PORTS-1:0]       vld_ff;
   pdd_pkg::entry_type         rd_ff;
   logic [pdd_pkg::CODE_W-1:0] stable_ff [NUM_PORTS];
   logic [pdd_pkg::CODE_W-1:0] stable_in [NUM_PORTS];

   logic                       s1_valid_ff;
   logic [pdd_pkg::PORT_W-1:0] s1_port_ff;
   logic [pdd_pkg::CODE_W-1:0] s1_code_ff;
   logic                       s1_hit_ff;
   pdd_pkg::entry_type         s1_fwd_ff;

   logic                       rsp_valid_ff;
   logic [pdd_pkg::PORT_W-1:0] rsp_port_ff;
   logic [pdd_pkg::CODE_W-1:0] rsp_code_ff;
   logic [pdd_pkg::ID_W-1:0]   rsp_id_ff;

   logic                       out_free;
   logic                       s1_fire;
   logic                       req_fire;
   logic                       req_in_range;
   logic                       s1_in_range;
   logic [AW-1:0]              s1_idx;
   logic [AW-1:0]              req_idx;
   pdd_pkg::entry_type         cur;
   pdd_pkg::entry_type         nxt;
   logic [pdd_pkg::CODE_W-1:0] cur_stable;
   logic [pdd_pkg::CODE_W-1:0] nxt_stable;
   logic [pdd_pkg::CNT_W-1:0]  cnt_inc;
   logic [pdd_pkg::ID_W-1:0]   id_in;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_ready    = !s1_valid_ff || out_free;
   assign req_fire     = req_valid && req_ready;
   assign req_in_range = req_port < PORT_LIMIT;
   assign s1_in_range  = s1_port_ff < PORT_LIMIT;
   assign s1_idx       = s1_port_ff[AW-1:0];
   assign req_idx      = req_port[AW-1:0];

   always_comb begin
      if (s1_hit_ff) begin
         cur = s1_fwd_ff;
      end else if (s1_in_range && vld_ff[s1_idx]) begin
         cur = rd_ff;
      end else begin
         cur = '0;
      end
      cur_stable = s1_in_range ? stable_ff[s1_idx] : pdd_pkg::CODE_NOTHING;
      nxt        = cur;
      nxt_stable = cur_stable;
      cnt_inc    = '0;
      if (s1_code_ff != pdd_pkg::CODE_NOTHING) begin
         nxt.disc_cnt = '0;
         if (cur_stable == pdd_pkg::CODE_NOTHING && !cur.connecting) begin
            nxt.connecting = 1'b1;
            nxt.pending    = s1_code_ff;
         end else if (cur.connecting && cur.pending == s1_code_ff) begin
            cnt_inc = (cur.conn_cnt < pdd_pkg::COUNT_MAX) ? cur.conn_cnt + 1'b1 : cur.conn_cnt;
            nxt.conn_cnt = cnt_inc;
            if (cnt_inc > limit_ff) begin
               nxt_stable     = s1_code_ff;
               nxt.connecting = 1'b0;
               nxt.conn_cnt   = '0;
            end
         end else begin
            nxt.connecting = 1'b0;
            nxt.conn_cnt   = '0;
            nxt.pending    = pdd_pkg::CODE_NOTHING;
         end
      end else begin
         cnt_inc = (cur.disc_cnt < pdd_pkg::COUNT_MAX) ? cur.disc_cnt + 1'b1 : cur.disc_cnt;
         nxt.disc_cnt = cnt_inc;
         if (cnt_inc > limit_ff) begin
            nxt.disc_cnt = '0;
            nxt_stable   = pdd_pkg::CODE_NOTHING;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PORTS; i++) begin
         stable_in[i] = stable_ff[i];
      end
      if (s1_fire && s1_in_range) begin
         stable_in[s1_idx] = nxt_stable;
      end
   end

   always_comb begin
      id_in = '0;
      for (int i = 0; i < OUT_PORTS; i++) begin
         id_in[28 - 4*i +: 4] = stable_in[i];
      end
      for (int j = 0; j < IN_PORTS; j++) begin
         id_in[11 - 5*j +: 5] = {1'b0, stable_in[OUT_PORTS + j]};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_in_range) begin
         mem[s1_idx] <= nxt;
      end
      if (req_fire && req_in_range) begin
         rd_ff <= mem[req_idx];
      end
      if (req_fire) begin
         s1_port_ff <= req_port;
         s1_code_ff <= pdd_pkg::classify(req_sample);
         s1_hit_ff  <= s1_fire && s1_in_range && (s1_port_ff == req_port);
         s1_fwd_ff  <= nxt;
      end
      if (s1_fire) begin
         rsp_port_ff <= s1_port_ff;
         rsp_code_ff <= s1_in_range ? nxt_stable : pdd_pkg::CODE_NOTHING;
         rsp_id_ff   <= id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= pdd_pkg::LIMIT_RESET;
         vld_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PORTS; i++) begin
            stable_ff[i] <= pdd_pkg::CODE_NOTHING;
         end
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (s1_fire && s1_in_range) begin
            vld_ff[s1_idx] <= 1'b1;
         end
         for (int i = 0; i < NUM_PORTS; i++) begin
            stable_ff[i] <= stable_in[i];
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_port_out    = rsp_port_ff;
   assign rsp_stable_code = rsp_code_ff;
   assign rsp_identifier  = rsp_id_ff;

endmodule

### dv/port_device_debounce_checker.sv
// Checker for the port device detection debouncer: watches the item and result
// channels and the limit register, predicts each result and compares it.
// Depends on pdd_pkg.
`timescale 1ns / 100ps

module port_device_debounce_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pdd_pkg::CNT_W-1:0]           csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [pdd_pkg::PORT_W-1:0]          req_port,
   input  logic [7:0]                          req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [pdd_pkg::PORT_W-1:0]          rsp_port_out,
   input  logic [pdd_pkg::CODE_W-1:0]          rsp_stable_code,
   input  logic [pdd_pkg::ID_W-1:0]            rsp_identifier,
   output int                                  mismatches,
   output int                                  backlog,
   output int                                  checked,
   output int                                  commits
);

   localparam int NUM_OUT   = 4;
   localparam int NUM_IN    = 3;
   localparam int NUM_PORTS = NUM_OUT + NUM_IN;

   typedef struct packed {
      logic [pdd_pkg::PORT_W-1:0] port;
      logic [pdd_pkg::CODE_W-1:0] code;
      logic [pdd_pkg::ID_W-1:0]   id;
   } device_report_type;

   logic [pdd_pkg::CNT_W-1:0]  commit_limit;
   logic [pdd_pkg::CODE_W-1:0] settled   [NUM_PORTS];
   logic [pdd_pkg::CODE_W-1:0] candidate [NUM_PORTS];
   logic                       arming    [NUM_PORTS];
   logic [pdd_pkg::CNT_W-1:0]  arm_cnt   [NUM_PORTS];
   logic [pdd_pkg::CNT_W-1:0]  drop_cnt  [NUM_PORTS];

   device_report_type owed_reports[$];
   device_report_type want;
   device_report_type fresh;

   function automatic logic [pdd_pkg::CODE_W-1:0] voltage_to_device(input logic [7:0] v);
      if (v <= 8'd20)       return pdd_pkg::CODE_UNKNOWN;
      else if (v <= 8'd50)  return pdd_pkg::CODE_MATRIX;
      else if (v <= 8'd70)  return pdd_pkg::CODE_UNKNOWN;
      else if (v <= 8'd90)  return pdd_pkg::CODE_SERVO;
      else if (v <= 8'd100) return pdd_pkg::CODE_UNKNOWN;
      else if (v <= 8'd110) return pdd_pkg::CODE_LIGHT;
      else if (v <= 8'd120) return pdd_pkg::CODE_DISTANCE;
      else if (v <= 8'd130) return pdd_pkg::CODE_UNKNOWN;
      else if (v <= 8'd140) return pdd_pkg::CODE_DIAL;
      else if (v <= 8'd180) return pdd_pkg::CODE_UNKNOWN;
      else if (v <= 8'd240) return pdd_pkg::CODE_PLACE;
      else                  return pdd_pkg::CODE_NOTHING;
   endfunction

   function automatic logic [pdd_pkg::ID_W-1:0] port_map_id();
      logic [pdd_pkg::ID_W-1:0] id;
      id = '0;
      for (int i = 0; i < NUM_OUT; i++)
         id[28-4*i +: 4] = settled[i];
      for (int j = 0; j < NUM_IN; j++)
         id[11-5*j +: 5] = {1'b0, settled[NUM_OUT+j]};
      return id;
   endfunction

   task automatic debounce_port(input int p, input logic [7:0] v);
      logic [pdd_pkg::CODE_W-1:0] seen;
      seen = voltage_to_device(v);
      if (seen != pdd_pkg::CODE_NOTHING) begin
         drop_cnt[p] = '0;
         if (settled[p] == pdd_pkg::CODE_NOTHING && !arming[p]) begin
            arming[p]    = 1'b1;
            candidate[p] = seen;
         end else if (arming[p] && candidate[p] == seen) begin
            if (arm_cnt[p] != pdd_pkg::COUNT_MAX)
               arm_cnt[p] = arm_cnt[p] + 1'b1;
            if (arm_cnt[p] > commit_limit) begin
               settled[p] = seen;
               arming[p]  = 1'b0;
               arm_cnt[p] = '0;
               commits++;
            end
         end else begin
            arming[p]    = 1'b0;
            arm_cnt[p]   = '0;
            candidate[p] = pdd_pkg::CODE_NOTHING;
         end
      end else begin
         if (drop_cnt[p] != pdd_pkg::COUNT_MAX)
            drop_cnt[p] = drop_cnt[p] + 1'b1;
         if (drop_cnt[p] > commit_limit) begin
            drop_cnt[p] = '0;
            settled[p]  = pdd_pkg::CODE_NOTHING;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
      $display("%0t mismatch on %s: want %0h, got %0h", $time, what, want_v, got_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         commit_limit = pdd_pkg::LIMIT_RESET;
         for (int i = 0; i < NUM_PORTS; i++) begin
            settled[i]   = pdd_pkg::CODE_NOTHING;
            candidate[i] = pdd_pkg::CODE_NOTHING;
            arming[i]    = 1'b0;
            arm_cnt[i]   = '0;
            drop_cnt[i]  = '0;
         end
         owed_reports.delete();
         backlog = 0;
      end else begin
         if (csr_wr_en)
            commit_limit = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (owed_reports.size() == 0) begin
               report_mismatch("result with nothing owed", '0, rsp_identifier);
            end else begin
               want = owed_reports.pop_front();
               if (rsp_port_out != want.port)
                  report_mismatch("port_out", 32'(want.port), 32'(rsp_port_out));
               if (rsp_stable_code != want.code)
                  report_mismatch("stable_code", 32'(want.code), 32'(rsp_stable_code));
               if (rsp_identifier != want.id)
                  report_mismatch("identifier", want.id, rsp_identifier);
            end
         end
         if (req_valid && req_ready) begin
            fresh.port = req_port;
            fresh.code = pdd_pkg::CODE_NOTHING;
            if (req_port < NUM_PORTS) begin
               debounce_port(int'(req_port), req_sample);
               fresh.code = settled[req_port];
            end
            fresh.id = port_map_id();
            owed_reports.push_back(fresh);
         end
         backlog = owed_reports.size();
      end
   end

endmodule

### dv/port_device_detect_debounce_core_test.sv
// Testbench top for the port device detection debouncer: clock, reset, item
// and limit stimulus, result back-pressure and the final verdict.
// Depends on pdd_pkg, port_device_detect_debounce_core and port_device_debounce_checker.
`timescale 1ns / 100ps

module port_device_detect_debounce_core_test;

   localparam int IDLE_PCT    = 27;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en   = 1'b0;
   logic [pdd_pkg::CNT_W-1:0]  csr_wr_data = '0;
   logic                       req_valid   = 1'b0;
   logic [pdd_pkg::PORT_W-1:0] req_port    = '0;
   logic [7:0]                 req_sample  = '0;
   logic                       rsp_ready   = 1'b0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [pdd_pkg::PORT_W-1:0] rsp_port_out;
   logic [pdd_pkg::CODE_W-1:0] rsp_stable_code;
   logic [pdd_pkg::ID_W-1:0]   rsp_identifier;

   int mismatches;
   int backlog;
   int checked;
   int commits;
   int cycles      = 0;
   int items_sent  = 0;
   int limits_used = 1;
   bit calm        = 1'b0;
   bit squeeze     = 1'b0;
   int band_of_port [8];

   port_device_detect_debounce_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_port        (req_port),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_port_out    (rsp_port_out),
      .rsp_stable_code (rsp_stable_code),
      .rsp_identifier  (rsp_identifier)
   );

   port_device_debounce_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_port        (req_port),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_port_out    (rsp_port_out),
      .rsp_stable_code (rsp_stable_code),
      .rsp_identifier  (rsp_identifier),
      .mismatches      (mismatches),
      .backlog         (backlog),
      .checked         (checked),
      .commits         (commits)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic [7:0] border_voltage(input int k);
      case (k)
         0:  return 8'd0;
         1:  return 8'd20;
         2:  return 8'd21;
         3:  return 8'd50;
         4:  return 8'd51;
         5:  return 8'd70;
         6:  return 8'd71;
         7:  return 8'd90;
         8:  return 8'd91;
         9:  return 8'd100;
         10: return 8'd101;
         11: return 8'd110;
         12: return 8'd111;
         13: return 8'd120;
         14: return 8'd121;
         15: return 8'd130;
         16: return 8'd131;
         17: return 8'd140;
         18: return 8'd141;
         19: return 8'd180;
         20: return 8'd181;
         21: return 8'd240;
         22: return 8'd241;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [7:0] voltage_in_band(input int idx);
      case (idx)
         0:  return 8'($urandom_range(255, 241));
         1:  return 8'($urandom_range(110, 101));
         2:  return 8'($urandom_range(140, 131));
         3:  return 8'($urandom_range(120, 111));
         4:  return 8'($urandom_range(90, 71));
         5:  return 8'($urandom_range(50, 21));
         6:  return 8'($urandom_range(240, 181));
         7:  return 8'($urandom_range(20, 0));
         8:  return 8'($urandom_range(70, 51));
         9:  return 8'($urandom_range(100, 91));
         10: return 8'($urandom_range(130, 121));
         default: return 8'($urandom_range(180, 141));
      endcase
   endfunction

   task automatic offer(input int p, input logic [7:0] v);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_port   <= p[pdd_pkg::PORT_W-1:0];
      req_sample <= v;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   task automatic set_limit(input logic [pdd_pkg::CNT_W-1:0] lim);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limits_used++;
   endtask

   task automatic random_run(input int count, input int noise_pct, input int lim);
      int p;
      logic [7:0] v;
      for (int i = 0; i < count; i++) begin
         p = ($urandom_range(49) == 0) ? 7 : int'($urandom_range(6));
         if ($urandom_range(lim + 5) == 0)
            band_of_port[p] = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(11));
         if ($urandom_range(99) < noise_pct)
            v = 8'($urandom_range(255));
         else
            v = voltage_in_band(band_of_port[p]);
         offer(p, v);
      end
   endtask

   initial begin
      int lim;
      for (int i = 0; i < 8; i++)
         band_of_port[i] = int'($urandom_range(11));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // band borders at the reset limit, spread over all port indexes
      for (int k = 0; k < 24; k++)
         offer(k % 8, border_voltage(k));

      set_limit(4'd0);
      offer(3, 8'd0);
      offer(3, 8'd0);
      offer(3, 8'd45);
      offer(3, 8'd255);
      offer(6, 8'd235);
      offer(6, 8'd235);
      offer(5, 8'd81);
      offer(5, 8'd81);
      offer(1, 8'd101);
      offer(1, 8'd115);

      set_limit(4'd14);
      random_run(260, 5, 14);

      // back-to-back traffic with a long receiver hold-off
      set_limit(4'd5);
      calm    = 1'b1;
      squeeze = 1'b1;
      random_run(200, 10, 5);
      settle();
      calm = 1'b0;

      set_limit(4'd15);
      random_run(120, 10, 15);
      set_limit(4'd0);
      random_run(250, 15, 0);
      set_limit(4'd1);
      random_run(200, 10, 1);
      lim = int'($urandom_range(13, 2));
      set_limit(lim[pdd_pkg::CNT_W-1:0]);
      random_run(300, 10, lim);

      settle();
      repeat (4) @(posedge clock);
      $display("run drove %0d items across %0d debounce limits, %0d results compared",
               items_sent, limits_used, checked);
      $display("model saw %0d connections committed along the way", commits);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
